[src/jvc_pkg.sv]
// ----------------------------------------------------------------------------
// jvc_pkg - shared types and constants of the joystick velocity conditioner
// Sample format (Q1.15), register indexes, speed table and saturation.
// ----------------------------------------------------------------------------
package jvc_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 16;
	localparam int DZ_W        = 15;
	localparam int LEVEL_W     = 3;
	localparam int SPEED_STEPS = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// gain multiplier consumes the gain one digit per cycle, MSB digit first
	localparam int DIGIT_W     = 4;
	localparam int GAIN_DIGITS = GAIN_W / DIGIT_W;
	localparam int CNT_W       = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;
	localparam sample_t PAD_HALF_POS = 16'sh4000;
	localparam sample_t PAD_HALF_NEG = 16'shC000;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(SPEED_STEPS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} jvc_smooth_sts_t;

	// speed scale in eighths of full scale
	function automatic logic [3:0] speed_num(input logic [LEVEL_W-1:0] lvl);
		case (lvl)
			3'd0:    return 4'd1;
			3'd1:    return 4'd2;
			3'd2:    return 4'd4;
			3'd3:    return 4'd6;
			default: return 4'd8;
		endcase
	endfunction

	function automatic sample_t sat_sample(input logic signed [19:0] v);
		if (v > 20'(SAMPLE_MAX))
			return SAMPLE_MAX;
		else if (v < 20'(SAMPLE_MIN))
			return SAMPLE_MIN;
		else
			return v[SAMPLE_W-1:0];
	endfunction

endpackage

[src/jvc_if.sv]
// ----------------------------------------------------------------------------
// jvc_if - valid/ready channels of the joystick velocity conditioner
// Gamepad sample channel and velocity command channel.
// ----------------------------------------------------------------------------
interface jvc_sample_if import jvc_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t stick_fwd;
	sample_t stick_side;
	sample_t trig_left;
	sample_t trig_right;
	sample_t pad_vertical;
	sample_t pad_horizontal;
	logic    bump_left;
	logic    bump_right;
	logic    btn_back;
	logic    btn_start;

	modport source (
		output valid, stick_fwd, stick_side, trig_left, trig_right,
			pad_vertical, pad_horizontal, bump_left, bump_right, btn_back, btn_start,
		input  ready
	);
	modport sink (
		input  valid, stick_fwd, stick_side, trig_left, trig_right,
			pad_vertical, pad_horizontal, bump_left, bump_right, btn_back, btn_start,
		output ready
	);
endinterface

interface jvc_cmd_if import jvc_pkg::*;;
	logic               valid;
	logic               ready;
	sample_t            vel_x;
	sample_t            vel_y;
	sample_t            vel_z;
	sample_t            rot_z;
	logic               twist_valid;
	logic               tool_frame;
	logic [LEVEL_W-1:0] speed_level;
	logic               speed_stepped;

	modport source (
		output valid, vel_x, vel_y, vel_z, rot_z, twist_valid, tool_frame,
			speed_level, speed_stepped,
		input  ready
	);
	modport sink (
		input  valid, vel_x, vel_y, vel_z, rot_z, twist_valid, tool_frame,
			speed_level, speed_stepped,
		output ready
	);
endinterface

[src/joystick_velocity_conditioner_core.sv]
// ----------------------------------------------------------------------------
// joystick_velocity_conditioner_core - gamepad sample to velocity command
// Speed level, frame select, scaling, smoothing, deadzone and output floor.
// ----------------------------------------------------------------------------
//  channel     dir   handshake        word
//  sample_in   in    valid/ready      six Q1.15 axes, bumpers, back, start
//  cmd_out     out   valid/ready      vel x/y/z, rot z, flags, speed level
//  wr_*        in    wr_en only       register index and data, no read-back
//
//  A twist sample goes from accept to command in steps: form targets, launch,
//  smooth each axis in turn in the shared smoothing unit (4 gain digits plus
//  a round/add step), load the output register. A sample with the horizontal
//  pad set only forms targets and loads the register. Ready returns the cycle
//  after the load, so no new sample is taken while one is in flight. The
//  smoothing unit is the limit. Reset restores the configuration and control
//  state to its defaults. A stalled command holds in the output register; the
//  next sample is accepted meanwhile and its command waits for the register.
// ----------------------------------------------------------------------------
module joystick_velocity_conditioner_core import jvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	jvc_sample_if.sink            sample_in,
	jvc_cmd_if.source             cmd_out,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TGT    = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_SMOOTH = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	localparam logic [1:0] AX_LAST = 2'd3;
	localparam logic signed [16:0] Z_LIM = 17'sd32768;

	function automatic logic [16:0] abs17(input logic signed [16:0] v);
		return v[16] ? 17'(-v) : 17'(v);
	endfunction

	// x * num / 8, rounded to nearest with ties away from zero
	function automatic logic signed [17:0] scale_round(input logic signed [16:0] x,
		input logic [3:0] num);
		logic signed [21:0] p;
		logic [21:0]        m;
		logic [21:0]        r;
		p = 22'(x) * 22'($signed({1'b0, num}));
		m = p[21] ? 22'(-p) : 22'(p);
		r = (m + 22'd4) >> 3;
		return p[21] ? -$signed({1'b0, r[16:0]}) : $signed({1'b0, r[16:0]});
	endfunction

	function automatic sample_t floor_val(input sample_t v, input logic [DZ_W-1:0] fl);
		return (abs17(17'(v)) < 17'(fl)) ? '0 : v;
	endfunction

	// configuration
	logic [GAIN_W-1:0] gain_q;
	logic [DZ_W-1:0]   dz_q;
	logic [DZ_W-1:0]   floor_q;

	// control and conditioner state
	logic [2:0]         state_q;
	logic [1:0]         ax_q;
	logic [LEVEL_W-1:0] level_q;
	sample_t            last_pv_q;
	logic               last_back_q;
	logic               last_start_q;
	logic               frame_q;
	sample_t            smooth_q [4];
	logic               changed_q;
	logic               twist_q;
	logic               out_valid_q;

	// sample payload and targets
	sample_t fwd_q, side_q, tl_q, tr_q;
	logic    lb_q, rb_q;
	sample_t tgt_q [4];
	logic    en_q  [4];

	// output register payload
	sample_t            vx_q, vy_q, vz_q, rz_q;
	logic               tv_q, tf_q, sc_q;
	logic [LEVEL_W-1:0] sl_q;

	logic               accept;
	logic               step_up, step_dn;
	logic               back_rise, start_rise;
	logic [3:0]         num;
	logic signed [16:0] zd, zc;
	sample_t            tx, ty, tz, trot;
	logic [1:0]         ax_sel;
	logic               mul_start;
	sample_t            mul_res;
	jvc_smooth_sts_t    sts;
	logic               out_load;

	assign sample_in.ready = (state_q == ST_IDLE);
	assign accept          = sample_in.valid && sample_in.ready;

	assign step_up    = (sample_in.pad_vertical > PAD_HALF_POS) && (last_pv_q < PAD_HALF_POS);
	assign step_dn    = (sample_in.pad_vertical < PAD_HALF_NEG) && (last_pv_q > PAD_HALF_NEG);
	assign back_rise  = sample_in.btn_back && !last_back_q;
	assign start_rise = sample_in.btn_start && !last_start_q;

	always_comb begin
		num  = speed_num(level_q);
		zd   = 17'(tl_q) - 17'(tr_q);
		if (zd > Z_LIM)
			zc = Z_LIM;
		else if (zd < -Z_LIM)
			zc = -Z_LIM;
		else
			zc = zd;
		tx   = sat_sample(20'(scale_round(17'(fwd_q), num)));
		ty   = sat_sample(20'(scale_round(17'(side_q), num)));
		tz   = sat_sample(-20'(scale_round(zc, num)));
		case ({lb_q, rb_q})
			2'b10:   trot = SAMPLE_MAX;
			2'b01:   trot = SAMPLE_MIN;
			default: trot = '0;
		endcase
	end

	// launch axis 0, then chain each next axis off the previous completion
	assign ax_sel    = (state_q == ST_SMOOTH) ? ax_q + 2'd1 : ax_q;
	assign mul_start = (state_q == ST_LAUNCH) ||
		((state_q == ST_SMOOTH) && sts.done && (ax_q != AX_LAST));

	jvc_smooth u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.target (tgt_q[ax_sel]),
		.prev   (smooth_q[ax_sel]),
		.gain   (gain_q),
		.result (mul_res),
		.sts    (sts)
	);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || cmd_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd16384;
			dz_q    <= 15'd3277;
			floor_q <= 15'd33;
		end else if (wr_en) begin
			case (wr_index)
				REG_GAIN:     gain_q  <= wr_data;
				REG_DEADZONE: dz_q    <= wr_data[DZ_W-1:0];
				REG_FLOOR:    floor_q <= wr_data[DZ_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ax_q         <= '0;
			level_q      <= LEVEL_RESET;
			last_pv_q    <= '0;
			last_back_q  <= 1'b0;
			last_start_q <= 1'b0;
			frame_q      <= 1'b0;
			changed_q    <= 1'b0;
			twist_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < 4; i++)
				smooth_q[i] <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (cmd_out.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						changed_q <= 1'b0;
						if (step_up) begin
							if (level_q < LEVEL_MAX) begin
								level_q   <= level_q + 1'b1;
								changed_q <= 1'b1;
							end
						end else if (step_dn) begin
							if (level_q != '0) begin
								level_q   <= level_q - 1'b1;
								changed_q <= 1'b1;
							end
						end
						if (back_rise && frame_q)
							frame_q <= 1'b0;
						else if (start_rise && !frame_q)
							frame_q <= 1'b1;
						last_pv_q    <= sample_in.pad_vertical;
						last_back_q  <= sample_in.btn_back;
						last_start_q <= sample_in.btn_start;
						twist_q      <= (sample_in.pad_horizontal == '0);
						state_q      <= ST_TGT;
					end
				end
				ST_TGT: begin
					ax_q    <= '0;
					state_q <= twist_q ? ST_LAUNCH : ST_OUT;
				end
				ST_LAUNCH: begin
					state_q <= ST_SMOOTH;
				end
				ST_SMOOTH: begin
					if (sts.done) begin
						smooth_q[ax_q] <= en_q[ax_q] ? mul_res : '0;
						if (ax_q == AX_LAST)
							state_q <= ST_OUT;
						else
							ax_q <= ax_q + 2'd1;
					end
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q  <= sample_in.stick_fwd;
			side_q <= sample_in.stick_side;
			tl_q   <= sample_in.trig_left;
			tr_q   <= sample_in.trig_right;
			lb_q   <= sample_in.bump_left;
			rb_q   <= sample_in.bump_right;
		end
		if (state_q == ST_TGT) begin
			tgt_q[0] <= tx;
			tgt_q[1] <= ty;
			tgt_q[2] <= tz;
			tgt_q[3] <= trot;
			en_q[0]  <= abs17(17'(fwd_q)) > 17'(dz_q);
			en_q[1]  <= abs17(17'(side_q)) > 17'(dz_q);
			en_q[2]  <= abs17(zd) > 17'(dz_q);
			en_q[3]  <= lb_q || rb_q;
		end
		if (out_load) begin
			// joint-jog words report zero velocity
			vx_q <= twist_q ? floor_val(smooth_q[0], floor_q) : '0;
			vy_q <= twist_q ? floor_val(smooth_q[1], floor_q) : '0;
			vz_q <= twist_q ? floor_val(smooth_q[2], floor_q) : '0;
			rz_q <= twist_q ? floor_val(smooth_q[3], floor_q) : '0;
			tv_q <= twist_q;
			tf_q <= frame_q;
			sl_q <= level_q;
			sc_q <= changed_q;
		end
	end

	assign cmd_out.valid         = out_valid_q;
	assign cmd_out.vel_x         = vx_q;
	assign cmd_out.vel_y         = vy_q;
	assign cmd_out.vel_z         = vz_q;
	assign cmd_out.rot_z         = rz_q;
	assign cmd_out.twist_valid   = tv_q;
	assign cmd_out.tool_frame    = tf_q;
	assign cmd_out.speed_level   = sl_q;
	assign cmd_out.speed_stepped = sc_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LEVEL_MAX)
		else $error("speed level out of table range");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> (!sts.busy || sts.done))
		else $error("smoothing unit started while busy");

	a_jog_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_out.valid && !cmd_out.twist_valid) |->
			(cmd_out.vel_x == '0 && cmd_out.vel_y == '0 &&
			 cmd_out.vel_z == '0 && cmd_out.rot_z == '0))
		else $error("joint-jog word carries nonzero velocity");

	a_smooth_only_twist: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> twist_q)
		else $error("smoothing runs on a joint-jog sample");

endmodule

[src/jvc_smooth.sv]
// ----------------------------------------------------------------------------
// jvc_smooth - digit-serial exponential smoothing step
// s + round((t - s) * gain / 2^15), saturated; gain taken 4 bits per cycle.
// ----------------------------------------------------------------------------
module jvc_smooth import jvc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sample_t             target,
	input  sample_t             prev,
	input  logic [GAIN_W-1:0]   gain,
	output sample_t             result,
	output jvc_smooth_sts_t     sts
);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [16:0] d_q;
	sample_t            s_q;
	logic [GAIN_W-1:0]  g_q;
	logic signed [33:0] acc_q;

	logic signed [21:0] dprod;
	logic signed [33:0] acc_next;
	logic [33:0]        mag;
	logic [33:0]        rnd;
	logic signed [19:0] rs;
	logic signed [19:0] sum;

	always_comb begin
		dprod    = 22'(d_q) * 22'($signed({1'b0, g_q[GAIN_W-1 -: DIGIT_W]}));
		acc_next = (acc_q <<< DIGIT_W) + 34'(dprod);
		mag      = acc_q[33] ? 34'(-acc_q) : 34'(acc_q);
		rnd      = (mag + 34'd16384) >> 15;
		rs       = acc_q[33] ? -$signed({3'b000, rnd[16:0]}) : $signed({3'b000, rnd[16:0]});
		sum      = 20'(s_q) + rs;
	end

	assign result   = sat_sample(sum);
	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(GAIN_DIGITS);
		end else if (busy_q) begin
			if (cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
			else
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= 17'(target) - 17'(prev);
			s_q   <= prev;
			g_q   <= (gain > GAIN_ONE) ? GAIN_ONE : gain;
			acc_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			// advance one gain digit
			acc_q <= acc_next;
			g_q   <= g_q << DIGIT_W;
		end
	end

endmodule
